### hw/rtl/sonar_echo_ranging_tracker_macros.svh
// ----------------------------------------------------------------------------
// Sonar echo ranging tracker assertion macros
// Concurrent assertion wrappers. They expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SONAR_ECHO_RANGING_TRACKER_MACROS_SVH
`define SONAR_ECHO_RANGING_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define SERT_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SERT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SERT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SERT_ASSERT(lbl, clk, rst_n, cond, msg)
`define SERT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SERT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/sert_pkg.sv
// ----------------------------------------------------------------------------
// Sonar echo ranging tracker package
// Field widths, register codes, operation codes and shared helpers.
// ----------------------------------------------------------------------------
package sert_pkg;

  localparam int unsigned CHANNEL_COUNT_DEF = 4;
  localparam int unsigned TIME_WIDTH_DEF    = 32;

  localparam int unsigned CH_W       = 2;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned DIST_W     = 10;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned LIMIT_W    = 7;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned RECIP_W    = 17;
  localparam int unsigned CM_SHIFT   = 22;

  localparam logic [COUNT_W-1:0]   COUNT_SAT  = 8'd255;
  localparam logic [ELAPSED_W-1:0] CM_DIVISOR = 16'd59;
  // ceil(2^22 / 59): exact floor division for any elapsed below 2^16
  localparam logic [RECIP_W-1:0]   CM_RECIP   = 17'd71090;

  localparam logic [LIMIT_W-1:0] LOST_LIMIT_RST = 7'd13;
  localparam logic [DIST_W-1:0]  MAX_DIST_RST   = 10'd400;

  localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST   = 2'd1;

  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned MID_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_TICK,
    OP_RISE,
    OP_FALL
  } op_e;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [DIST_W-1:0] distance;
    logic              ok;
    logic [MASK_W-1:0] mask;
  } result_t;

  function automatic logic [COUNT_W-1:0] relax_count(input logic [COUNT_W-1:0] cnt,
                                                     input logic [LIMIT_W-1:0] lim);
    logic [COUNT_W-1:0] two_lim;
    logic [COUNT_W-1:0] res;
    two_lim = {lim, 1'b0};
    if (cnt > two_lim) begin
      res = (two_lim == '0) ? '0 : two_lim - 8'd1;
    end else if (cnt >= {1'b0, lim}) begin
      res = (cnt < 8'd2) ? '0 : cnt - 8'd2;
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

### hw/rtl/sert_fifo.sv
// ----------------------------------------------------------------------------
// Sonar tracker FIFO
// Small register FIFO with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`include "sonar_echo_ranging_tracker_macros.svh"

module sert_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             wr_en, rd_en;

  assign full_o  = (count_q == NW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SERT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= NW'(DEPTH), "fifo count overflow")
  `SERT_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, wr_en && !rd_en, !empty_o, "pushed beat lost")

endmodule

### hw/rtl/sert_front.sv
// ----------------------------------------------------------------------------
// Sonar tracker front end
// Accepts input beats, classifies them into operations, queues them.
// ----------------------------------------------------------------------------
module sert_front #(
  parameter int unsigned CHANNEL_COUNT = sert_pkg::CHANNEL_COUNT_DEF,
  parameter int unsigned TIME_WIDTH    = sert_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        cmd_i,
  input  logic [sert_pkg::CH_W-1:0]   channel_i,
  input  logic                        echo_level_i,
  input  logic [sert_pkg::TS_W-1:0]   timestamp_us_i,
  output logic                        op_valid_o,
  input  logic                        op_ready_i,
  output sert_pkg::op_e               op_o,
  output logic [sert_pkg::CH_W-1:0]   op_channel_o,
  output logic [TIME_WIDTH-1:0]       op_ts_o
);
  import sert_pkg::*;

  localparam int unsigned ITEM_W = $bits(op_e) + CH_W + TIME_WIDTH;

  op_e               op;
  logic [ITEM_W-1:0] wr_item, rd_item;
  logic              empty;

  always_comb begin
    if (cmd_i) begin
      op = OP_TICK;
    end else if (32'(channel_i) >= CHANNEL_COUNT) begin
      op = OP_NOP;
    end else if (echo_level_i) begin
      op = OP_RISE;
    end else begin
      op = OP_FALL;
    end
  end

  assign wr_item = {op, channel_i, TIME_WIDTH'(timestamp_us_i)};

  sert_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(MID_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (wr_item),
    .full_o (full),
    .pop_i  (op_ready_i),
    .data_o (rd_item),
    .empty_o(empty)
  );

  assign op_valid_o   = !empty;
  assign op_o         = op_e'(rd_item[ITEM_W-1 -: $bits(op_e)]);
  assign op_channel_o = rd_item[TIME_WIDTH +: CH_W];
  assign op_ts_o      = rd_item[TIME_WIDTH-1:0];

endmodule

### hw/rtl/sert_back.sv
// ----------------------------------------------------------------------------
// Sonar tracker back end
// Holds channel state, executes operations, scales time to cm, queues results.
// ----------------------------------------------------------------------------
`include "sonar_echo_ranging_tracker_macros.svh"

module sert_back #(
  parameter int unsigned CHANNEL_COUNT = sert_pkg::CHANNEL_COUNT_DEF,
  parameter int unsigned TIME_WIDTH    = sert_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           op_valid_i,
  output logic                           op_ready_o,
  input  sert_pkg::op_e                  op_i,
  input  logic [sert_pkg::CH_W-1:0]      op_channel_i,
  input  logic [TIME_WIDTH-1:0]          op_ts_i,
  input  logic [sert_pkg::LIMIT_W-1:0]   lost_limit_i,
  input  logic [sert_pkg::DIST_W-1:0]    max_dist_i,
  output logic                           empty,
  input  logic                           pop,
  output sert_pkg::result_t              result_o
);
  import sert_pkg::*;

  localparam int unsigned CW  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned PW  = ELAPSED_W + RECIP_W;
  localparam int unsigned RW  = $bits(result_t);

  logic [TIME_WIDTH-1:0] start_q [CHANNEL_COUNT];
  logic [TIME_WIDTH-1:0] start_d [CHANNEL_COUNT];
  logic [COUNT_W-1:0]    lost_q  [CHANNEL_COUNT];
  logic [COUNT_W-1:0]    lost_d  [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] flags_q, flags_d;
  logic [CHANNEL_COUNT+MASK_W-1:0] flags_pad;

  logic                  a_valid_q, a_valid_d;
  logic [CH_W-1:0]       a_channel_q;
  logic                  a_ok_q;
  logic [ELAPSED_W-1:0]  a_elapsed_q;
  logic [MASK_W-1:0]     a_mask_q;

  logic [CW-1:0]         idx;
  logic [TIME_WIDTH-1:0] start_sel, elapsed;
  logic [ELAPSED_W-1:0]  bound;
  logic                  fall_ok, ok, fire, a_ready, out_full;
  logic [PW-1:0]         prod;
  result_t               res;
  logic [RW-1:0]         out_data;

  assign idx       = CW'(op_channel_i);
  assign start_sel = start_q[idx];
  assign elapsed   = op_ts_i - start_sel;
  assign bound     = ELAPSED_W'(max_dist_i) * CM_DIVISOR;
  assign fall_ok   = (op_ts_i > start_sel)
                  && (elapsed >= TIME_WIDTH'(CM_DIVISOR))
                  && (elapsed < TIME_WIDTH'(bound));

  assign a_ready    = !a_valid_q || !out_full;
  assign op_ready_o = a_ready;
  assign fire       = op_valid_i && a_ready;
  assign ok         = fire && (op_i == OP_FALL) && fall_ok;

  always_comb begin
    start_d = start_q;
    lost_d  = lost_q;
    flags_d = flags_q;
    if (fire) begin
      unique case (op_i)
        OP_TICK: begin
          for (int i = 0; i < CHANNEL_COUNT; i++) begin
            flags_d[i] = ({1'b0, lost_limit_i} > lost_q[i]);
            lost_d[i]  = (lost_q[i] == COUNT_SAT) ? COUNT_SAT : lost_q[i] + 8'd1;
          end
        end
        OP_RISE: start_d[idx] = op_ts_i;
        OP_FALL: begin
          if (fall_ok) begin
            lost_d[idx] = relax_count(lost_q[idx], lost_limit_i);
          end
        end
        OP_NOP: ;
        default: ;
      endcase
    end
  end

  assign flags_pad = {{MASK_W{1'b0}}, flags_d};
  assign a_valid_d = a_ready ? fire : a_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        start_q[i] <= '0;
        lost_q[i]  <= '0;
      end
      flags_q   <= '0;
      a_valid_q <= 1'b0;
    end else begin
      start_q   <= start_d;
      lost_q    <= lost_d;
      flags_q   <= flags_d;
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      a_channel_q <= op_channel_i;
      a_ok_q      <= ok;
      a_elapsed_q <= elapsed[ELAPSED_W-1:0];
      a_mask_q    <= flags_pad[MASK_W-1:0];
    end
  end

  assign prod = PW'(a_elapsed_q) * PW'(CM_RECIP);

  always_comb begin
    res.channel  = a_channel_q;
    res.ok       = a_ok_q;
    res.distance = a_ok_q ? prod[CM_SHIFT +: DIST_W] : '0;
    res.mask     = a_mask_q;
  end

  sert_fifo #(
    .WIDTH(RW),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (a_valid_q),
    .data_i (res),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_data),
    .empty_o(empty)
  );

  assign result_o = result_t'(out_data);

  `SERT_ASSERT_IMPL(a_ok_min, clk_i, rst_ni, a_valid_q && a_ok_q,
                    a_elapsed_q >= CM_DIVISOR, "valid distance below one cm")
  `SERT_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, a_valid_q && out_full,
                    a_valid_q, "stalled result dropped")
  `SERT_ASSERT_NEXT(a_tick_count, clk_i, rst_ni, fire && op_i == OP_TICK,
                    lost_q[0] != '0, "tick left count at zero")

endmodule

### hw/rtl/sonar_echo_ranging_tracker.sv
// ----------------------------------------------------------------------------
// Sonar echo ranging tracker
// Multi-channel echo pulse ranger with per-channel loss tracking.
// ----------------------------------------------------------------------------
// channel   handshake           payload
// input     push / full         cmd_i channel_i echo_level_i timestamp_us_i
// result    empty / pop         channel_out_o distance_cm_o distance_ok_o available_mask_o
// config    cfg_valid_i/_ready_o cfg_index_i cfg_data_i
//
// One beat per cycle sustained while the result queue is not full. A pushed beat
// passes the input queue, the execute stage (state update, elapsed time check),
// then the scale (multiply by reciprocal of 59) feeds the result queue.
// Reset clears all channel state and loads register defaults; no clearing pass.
// A full result queue stalls the execute stage, which backs up into the input
// queue; config writes are always accepted.
// ----------------------------------------------------------------------------
module sonar_echo_ranging_tracker #(
  parameter int unsigned CHANNEL_COUNT = sert_pkg::CHANNEL_COUNT_DEF,
  parameter int unsigned TIME_WIDTH    = sert_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              cmd_i,
  input  logic [sert_pkg::CH_W-1:0]         channel_i,
  input  logic                              echo_level_i,
  input  logic [sert_pkg::TS_W-1:0]         timestamp_us_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [sert_pkg::CH_W-1:0]         channel_out_o,
  output logic [sert_pkg::DIST_W-1:0]       distance_cm_o,
  output logic                              distance_ok_o,
  output logic [sert_pkg::MASK_W-1:0]       available_mask_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sert_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sert_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sert_pkg::*;

  logic [LIMIT_W-1:0]    lost_limit_q;
  logic [DIST_W-1:0]     max_dist_q;
  logic                  op_valid, op_ready;
  op_e                   op;
  logic [CH_W-1:0]       op_channel;
  logic [TIME_WIDTH-1:0] op_ts;
  result_t               result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_limit_q <= LOST_LIMIT_RST;
      max_dist_q   <= MAX_DIST_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOST_LIMIT: lost_limit_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_MAX_DIST:   max_dist_q   <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  sert_front #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .cmd_i         (cmd_i),
    .channel_i     (channel_i),
    .echo_level_i  (echo_level_i),
    .timestamp_us_i(timestamp_us_i),
    .op_valid_o    (op_valid),
    .op_ready_i    (op_ready),
    .op_o          (op),
    .op_channel_o  (op_channel),
    .op_ts_o       (op_ts)
  );

  sert_back #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .op_channel_i(op_channel),
    .op_ts_i     (op_ts),
    .lost_limit_i(lost_limit_q),
    .max_dist_i  (max_dist_q),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result)
  );

  assign channel_out_o    = result.channel;
  assign distance_cm_o    = result.distance;
  assign distance_ok_o    = result.ok;
  assign available_mask_o = result.mask;

endmodule
